// ----- rtl/tlrts_pkg.sv -----
// Shared widths, word types and the coordinate clamp for the triangle setup core.
package tlrts_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;

	// derived widths
	localparam int AW         = COORD_BITS + 1;        // |delta|
	localparam int LZ_BITS    = $clog2(AW);
	localparam int SW         = COORD_BITS + FRAC_BITS; // second operand / rect side
	localparam int NORM_TOP   = 29;
	localparam int NORM_BITS  = 30;
	localparam int SQ_BITS    = 62;
	localparam int ROOT_BITS  = 31;
	localparam int DEN_BITS   = ROOT_BITS + 9;
	localparam int QB         = FRAC_BITS + 8;
	localparam int NUM_BITS   = 47 + FRAC_BITS;
	localparam int PROD_BITS  = NORM_BITS + 16;
	localparam int SIDE_W     = 16 + FRAC_BITS;
	localparam int SUMW       = SW + 2;

	// squared length at or below this is a zero-length line
	localparam longint unsigned DEG_LIM = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

	typedef struct packed {
		logic                         operation;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] second_x;
		logic signed [COORD_BITS-1:0] second_y;
		logic [15:0]                  thickness;
		logic [7:0]                   color_red;
		logic [7:0]                   color_green;
		logic [7:0]                   color_blue;
		logic [7:0]                   color_alpha;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic [7:0]                   out_red;
		logic [7:0]                   out_green;
		logic [7:0]                   out_blue;
		logic [7:0]                   out_alpha;
		logic                         last_vertex;
	} vtx_t;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SUMW-1:0] v);
		logic signed [SUMW-1:0] hi;
		logic signed [SUMW-1:0] lo;
		hi = SUMW'({1'b0, {(COORD_BITS-1){1'b1}}});
		lo = ~hi;
		if (v > hi)
			return hi[COORD_BITS-1:0];
		else if (v < lo)
			return lo[COORD_BITS-1:0];
		else
			return v[COORD_BITS-1:0];
	endfunction

endpackage

// ----- rtl/tlrts_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module tlrts_sqrt
	import tlrts_pkg::*;
(
	input  logic                 clk,
	input  logic                 adv,
	input  logic [SQ_BITS-1:0]   sq,
	output logic [ROOT_BITS-1:0] root
);

	logic [SQ_BITS-1:0]   rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0] root_s [ROOT_BITS];

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
		localparam int BI = ROOT_BITS - 1 - j;
		logic [SQ_BITS-1:0]   m_in;
		logic [ROOT_BITS-1:0] r_in;
		logic [63:0]          t;
		logic                 take;

		if (j == 0) begin : g_first
			assign m_in = sq;
			assign r_in = '0;
		end else begin : g_next
			assign m_in = rem_s[j-1];
			assign r_in = root_s[j-1];
		end

		// (root + 2^i)^2 - root^2
		assign t    = (64'(r_in) << (BI + 1)) + (64'd1 << (2 * BI));
		assign take = 64'(m_in) >= t;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j]  <= take ? SQ_BITS'(64'(m_in) - t) : m_in;
				root_s[j] <= take ? (r_in | (ROOT_BITS'(1) << BI)) : r_in;
			end
		end
	end

	assign root = root_s[ROOT_BITS-1];

endmodule

// ----- rtl/tlrts_div.sv -----
// Pipelined restoring divider for the normal magnitude, one quotient bit per stage.
module tlrts_div
	import tlrts_pkg::*;
(
	input  logic                clk,
	input  logic                adv,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic [QB-1:0]       quo
);

	logic [NUM_BITS-1:0] rem_s [QB];
	logic [DEN_BITS-1:0] den_s [QB];
	logic [QB-1:0]       q_s   [QB];

	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int SH = QB - 1 - j;
		logic [NUM_BITS-1:0] r_in;
		logic [NUM_BITS-1:0] dsh;
		logic [DEN_BITS-1:0] d_in;
		logic [QB-1:0]       q_in;
		logic                take;

		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign d_in = den_s[j-1];
			assign q_in = q_s[j-1];
		end

		assign dsh  = NUM_BITS'(d_in) << SH;
		assign take = r_in >= dsh;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= take ? (r_in - dsh) : r_in;
				den_s[j] <= d_in;
				q_s[j]   <= {q_in[QB-2:0], take};
			end
		end
	end

	assign quo = q_s[QB-1];

endmodule

// ----- rtl/thick_line_and_rect_triangle_setup_core.sv -----
// Throughput: a new command may enter every cycle while cmd_stall is low;
// vertices leave one per cycle while vtx_stall is low, so commands that yield
// six vertices are held to the pace of the output word port; commands yielding
// none retire one per cycle while the serializer is free to take a command.
// The 31-stage root and 16-stage quotient pipelines set the depth.
// Reset (arst_n low) clears all valid bits and the vertex serializer.
module thick_line_and_rect_triangle_setup_core
	import tlrts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic vtx_valid,
	input  logic vtx_stall,
	output vtx_t vtx
);

	localparam int ST_DIFF = 2;
	localparam int ST_LZ   = 3;
	localparam int ST_NORM = 4;
	localparam int ST_SQ   = 5;
	localparam int ST_SUM  = 6;
	localparam int ST_ROOT = ST_SUM + ROOT_BITS;
	localparam int ST_NUM  = ST_ROOT + 1;
	localparam int ST_QUO  = ST_NUM + QB;
	localparam int ST_PT   = ST_QUO + 1;

	typedef struct packed {
		logic                         is_line;
		logic                         emit;
		logic signed [COORD_BITS-1:0] x0;
		logic signed [COORD_BITS-1:0] y0;
		logic signed [SW-1:0]         sx;
		logic signed [SW-1:0]         sy;
		logic [15:0]                  thick;
		logic [7:0]                   red;
		logic [7:0]                   green;
		logic [7:0]                   blue;
		logic [7:0]                   alpha;
		logic                         nx_neg;
		logic                         ny_neg;
		logic                         nx_zero;
		logic                         ny_zero;
	} ctx_t;

	typedef struct packed {
		logic                         emit;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] dx;
		logic signed [COORD_BITS-1:0] dy;
		logic [7:0]                   red;
		logic [7:0]                   green;
		logic [7:0]                   blue;
		logic [7:0]                   alpha;
	} pt_t;

	logic              adv;
	logic              ser_free;
	logic [ST_PT:1]    vld_s;

	cmd_t              in_s1;
	ctx_t              ctx_s [ST_DIFF:ST_QUO];
	logic [AW-1:0]     ax_s2, ay_s2;
	logic [LZ_BITS-1:0] p_s3;
	logic [AW-1:0]     a_s3, b_s3;
	logic [NORM_BITS-1:0] na_s4, nb_s4, na_s5, nb_s5;
	logic [2*NORM_BITS-1:0] sqa_s5, sqb_s5;
	logic [SQ_BITS-1:0] sum_s6;
	logic [PROD_BITS-1:0] pa_s [ST_SUM:ST_ROOT];
	logic [PROD_BITS-1:0] pb_s [ST_SUM:ST_ROOT];
	logic [ROOT_BITS-1:0] root;
	logic [NUM_BITS-1:0] numx_s, numy_s;
	logic [DEN_BITS-1:0] den_s;
	logic [QB-1:0]     qx, qy;
	pt_t               pt_s;

	pt_t               buf_q;
	logic [2:0]        cnt_q;
	logic              busy_q;

	// ---------------- stage 2: deltas, zero-length test, context
	logic signed [AW-1:0] dx_c, dy_c;
	logic [AW-1:0]        ax_c, ay_c;
	logic [FRAC_BITS:0]   al_c, bl_c;
	logic [2*FRAC_BITS+2:0] small_c;
	logic                 degen_c;
	logic [SIDE_W-1:0]    side_c;
	logic signed [SW-1:0] side_s_c;
	logic signed [SW-1:0] sx_c, sy_c;
	ctx_t                 ctx_c;

	always_comb begin
		dx_c = AW'(in_s1.second_x) - AW'(in_s1.start_x);
		dy_c = AW'(in_s1.second_y) - AW'(in_s1.start_y);
		ax_c = dx_c[AW-1] ? AW'(-dx_c) : AW'(dx_c);
		ay_c = dy_c[AW-1] ? AW'(-dy_c) : AW'(dy_c);
		al_c = ax_c[FRAC_BITS:0];
		bl_c = ay_c[FRAC_BITS:0];
		small_c = (2*FRAC_BITS+3)'(al_c) * (2*FRAC_BITS+3)'(al_c)
			+ (2*FRAC_BITS+3)'(bl_c) * (2*FRAC_BITS+3)'(bl_c);
		degen_c = ((ax_c >> FRAC_BITS) == '0) && ((ay_c >> FRAC_BITS) == '0)
			&& (64'(small_c) <= DEG_LIM);
		side_c   = (SIDE_W'(in_s1.thickness) << FRAC_BITS) >> 8;
		side_s_c = SW'($signed({1'b0, side_c}));
		sx_c     = SW'(in_s1.second_x);
		sy_c     = SW'(in_s1.second_y);

		ctx_c.x0      = in_s1.start_x;
		ctx_c.y0      = in_s1.start_y;
		ctx_c.thick   = in_s1.thickness;
		ctx_c.red     = in_s1.color_red;
		ctx_c.green   = in_s1.color_green;
		ctx_c.blue    = in_s1.color_blue;
		ctx_c.alpha   = in_s1.color_alpha;
		ctx_c.nx_neg  = !dy_c[AW-1] && (dy_c != '0);
		ctx_c.ny_neg  = dx_c[AW-1];
		ctx_c.nx_zero = dy_c == '0;
		ctx_c.ny_zero = dx_c == '0;
		if (in_s1.operation && !degen_c) begin
			ctx_c.is_line = 1'b1;
			ctx_c.emit    = 1'b1;
			ctx_c.sx      = sx_c;
			ctx_c.sy      = sy_c;
		end else if (in_s1.operation) begin
			// zero-length line: square of side thickness
			ctx_c.is_line = 1'b0;
			ctx_c.emit    = side_c != '0;
			ctx_c.sx      = side_s_c;
			ctx_c.sy      = side_s_c;
		end else begin
			ctx_c.is_line = 1'b0;
			ctx_c.emit    = (sx_c > 0) && (sy_c > 0);
			ctx_c.sx      = sx_c;
			ctx_c.sy      = sy_c;
		end
	end

	// ---------------- stage 3: leading-one position of the larger delta
	logic [AW-1:0]      mx_c;
	logic [LZ_BITS-1:0] p_c;

	always_comb begin
		mx_c = (ax_s2 > ay_s2) ? ax_s2 : ay_s2;
		p_c  = '0;
		for (int k = 0; k < AW; k++) begin
			if (mx_c[k])
				p_c = LZ_BITS'(k);
		end
	end

	// ---------------- stage 4: normalize so the larger lands in [2^29, 2^30)
	logic [AW+NORM_TOP-1:0] ta_c, tb_c;

	always_comb begin
		ta_c = ((AW+NORM_TOP)'(a_s3) << NORM_TOP) >> p_s3;
		tb_c = ((AW+NORM_TOP)'(b_s3) << NORM_TOP) >> p_s3;
	end

	// ---------------- final stage: normal and the four corners
	logic signed [QB:0]      nx_c, ny_c;
	logic signed [SUMW-1:0]  nxe, nye, x0e, y0e, sxe, sye;
	pt_t                     pt_c;
	ctx_t                    cf;

	always_comb begin
		cf   = ctx_s[ST_QUO];
		nx_c = cf.nx_zero ? '0 : (cf.nx_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
		ny_c = cf.ny_zero ? '0 : (cf.ny_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
		nxe  = SUMW'(nx_c);
		nye  = SUMW'(ny_c);
		x0e  = SUMW'(cf.x0);
		y0e  = SUMW'(cf.y0);
		sxe  = SUMW'(cf.sx);
		sye  = SUMW'(cf.sy);

		pt_c.emit  = cf.emit;
		pt_c.red   = cf.red;
		pt_c.green = cf.green;
		pt_c.blue  = cf.blue;
		pt_c.alpha = cf.alpha;
		if (cf.is_line) begin
			pt_c.ax = sat_coord(x0e + nxe);
			pt_c.ay = sat_coord(y0e + nye);
			pt_c.bx = sat_coord(sxe + nxe);
			pt_c.by = sat_coord(sye + nye);
			pt_c.cx = sat_coord(sxe - nxe);
			pt_c.cy = sat_coord(sye - nye);
			pt_c.dx = sat_coord(x0e - nxe);
			pt_c.dy = sat_coord(y0e - nye);
		end else begin
			pt_c.ax = sat_coord(x0e);
			pt_c.ay = sat_coord(y0e);
			pt_c.bx = sat_coord(x0e + sxe);
			pt_c.by = sat_coord(y0e);
			pt_c.cx = sat_coord(x0e + sxe);
			pt_c.cy = sat_coord(y0e + sye);
			pt_c.dx = sat_coord(x0e);
			pt_c.dy = sat_coord(y0e + sye);
		end
	end

	// ---------------- pipeline registers
	assign ser_free  = !busy_q || ((cnt_q == 3'd5) && !vtx_stall);
	assign adv       = !vld_s[ST_PT] || ser_free;
	assign cmd_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[ST_PT-1:1], cmd_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1          <= cmd;
			ctx_s[ST_DIFF] <= ctx_c;
			for (int k = ST_DIFF + 1; k <= ST_QUO; k++)
				ctx_s[k] <= ctx_s[k-1];
			ax_s2  <= ax_c;
			ay_s2  <= ay_c;
			p_s3   <= p_c;
			a_s3   <= ax_s2;
			b_s3   <= ay_s2;
			na_s4  <= ta_c[NORM_BITS-1:0];
			nb_s4  <= tb_c[NORM_BITS-1:0];
			na_s5  <= na_s4;
			nb_s5  <= nb_s4;
			sqa_s5 <= (2*NORM_BITS)'(na_s4) * (2*NORM_BITS)'(na_s4);
			sqb_s5 <= (2*NORM_BITS)'(nb_s4) * (2*NORM_BITS)'(nb_s4);
			sum_s6 <= SQ_BITS'(sqa_s5) + SQ_BITS'(sqb_s5);
			pa_s[ST_SUM] <= PROD_BITS'(na_s5) * PROD_BITS'(ctx_s[ST_SQ].thick);
			pb_s[ST_SUM] <= PROD_BITS'(nb_s5) * PROD_BITS'(ctx_s[ST_SQ].thick);
			for (int k = ST_SUM + 1; k <= ST_ROOT; k++) begin
				pa_s[k] <= pa_s[k-1];
				pb_s[k] <= pb_s[k-1];
			end
			// x magnitude uses |dy|, y magnitude uses |dx|; +L*256 rounds
			numx_s <= (NUM_BITS'(pb_s[ST_ROOT]) << FRAC_BITS) + (NUM_BITS'(root) << 8);
			numy_s <= (NUM_BITS'(pa_s[ST_ROOT]) << FRAC_BITS) + (NUM_BITS'(root) << 8);
			den_s  <= DEN_BITS'(root) << 9;
			pt_s   <= pt_c;
		end
	end

	tlrts_sqrt u_sqrt (
		.clk  (clk),
		.adv  (adv),
		.sq   (sum_s6),
		.root (root)
	);

	tlrts_div u_div_x (
		.clk (clk),
		.adv (adv),
		.num (numx_s),
		.den (den_s),
		.quo (qx)
	);

	tlrts_div u_div_y (
		.clk (clk),
		.adv (adv),
		.num (numy_s),
		.den (den_s),
		.quo (qy)
	);

	// ---------------- vertex serializer: A B C A C D
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ser_free && vld_s[ST_PT] && pt_s.emit) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (ser_free) begin
			busy_q <= 1'b0;
		end else if (busy_q && !vtx_stall) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_free && vld_s[ST_PT] && pt_s.emit)
			buf_q <= pt_s;
	end

	always_comb begin
		vtx.out_red     = buf_q.red;
		vtx.out_green   = buf_q.green;
		vtx.out_blue    = buf_q.blue;
		vtx.out_alpha   = buf_q.alpha;
		vtx.last_vertex = cnt_q == 3'd5;
		case (cnt_q)
			3'd1: begin
				vtx.vertex_x = buf_q.bx;
				vtx.vertex_y = buf_q.by;
			end
			3'd2, 3'd4: begin
				vtx.vertex_x = buf_q.cx;
				vtx.vertex_y = buf_q.cy;
			end
			3'd5: begin
				vtx.vertex_x = buf_q.dx;
				vtx.vertex_y = buf_q.dy;
			end
			default: begin
				vtx.vertex_x = buf_q.ax;
				vtx.vertex_y = buf_q.ay;
			end
		endcase
	end

	assign vtx_valid = busy_q;

endmodule

// ----- rtl/tlrts_checker.sv -----
// Port-level checks for the triangle setup core, bound to the top level.
module tlrts_checker
	import tlrts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic vtx_valid,
	input logic vtx_stall,
	input vtx_t vtx
);

	logic vtx_take;
	assign vtx_take = vtx_valid && !vtx_stall;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && vtx_stall |=> vtx_valid && $stable(vtx))
		else $error("vertex word changed under stall");

	// the six vertices of a command leave without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_take && !vtx.last_vertex |=> vtx_valid)
		else $error("gap inside a command");

	// color is the same on every vertex of a command
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_take && !vtx.last_vertex |=>
			vtx.out_red == $past(vtx.out_red) && vtx.out_green == $past(vtx.out_green)
			&& vtx.out_blue == $past(vtx.out_blue) && vtx.out_alpha == $past(vtx.out_alpha))
		else $error("color changed inside a command");

endmodule

bind thick_line_and_rect_triangle_setup_core tlrts_checker u_tlrts_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the thick line and rectangle triangle setup core.
module testbench;
	import tlrts_pkg::*;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic vtx_valid;
	logic vtx_stall;
	vtx_t vtx;

	localparam bit OP_RECT = 1'b0;
	localparam bit OP_LINE = 1'b1;
	localparam int WATCHDOG_LIMIT = 20000;

	cmd_t pending_cmds[$];
	vtx_t expected_vtx[$];
	int errors;
	bit stim_done;
	bit hold_off_req;
	bit pause_sender;
	int idle_cycles;
	bit cmd_acc;

	thick_line_and_rect_triangle_setup_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.vtx_valid(vtx_valid),
		.vtx_stall(vtx_stall),
		.vtx(vtx)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic push_vertex(input int k, input longint x, input longint y, input cmd_t c);
		vtx_t v;
		v.vertex_x = clamp_coord(x);
		v.vertex_y = clamp_coord(y);
		v.out_red = c.color_red;
		v.out_green = c.color_green;
		v.out_blue = c.color_blue;
		v.out_alpha = c.color_alpha;
		v.last_vertex = (k == 5);
		expected_vtx.insert(expected_vtx.size(), v);
	endtask

	task automatic push_quad(input longint x0, input longint y0, input longint w,
			input longint h, input cmd_t c);
		if (w <= 0 || h <= 0)
			return;
		push_vertex(0, x0, y0, c);
		push_vertex(1, x0 + w, y0, c);
		push_vertex(2, x0 + w, y0 + h, c);
		push_vertex(3, x0, y0, c);
		push_vertex(4, x0 + w, y0 + h, c);
		push_vertex(5, x0, y0 + h, c);
	endtask

	// expected vertices of one command
	task automatic expand_command(input cmd_t c);
		longint x0, y0, sx, sy, dx, dy, nx, ny;
		longint unsigned ax, ay, mx, len, den, magx, magy, thick;
		x0 = longint'(c.start_x);
		y0 = longint'(c.start_y);
		sx = longint'(c.second_x);
		sy = longint'(c.second_y);
		thick = c.thickness;
		if (c.operation == OP_RECT) begin
			push_quad(x0, y0, sx, sy, c);
			return;
		end
		dx = sx - x0;
		dy = sy - y0;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ax < (64'd1 << FRAC_BITS) && ay < (64'd1 << FRAC_BITS)) begin
			if ((ax * ax + ay * ay) * 64'd100000000 <= (64'd1 << (2 * FRAC_BITS))) begin
				push_quad(x0, y0, longint'((thick << FRAC_BITS) >> 8),
					longint'((thick << FRAC_BITS) >> 8), c);
				return;
			end
		end
		mx = ax > ay ? ax : ay;
		while (mx >= (64'd1 << 30)) begin
			ax >>= 1;
			ay >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			ax <<= 1;
			ay <<= 1;
			mx <<= 1;
		end
		len = int_sqrt(ax * ax + ay * ay);
		den = len << 9;
		magx = (((ay * thick) << FRAC_BITS) + (len << 8)) / den;
		magy = (((ax * thick) << FRAC_BITS) + (len << 8)) / den;
		nx = (dy > 0) ? -longint'(magx) : longint'(magx);
		ny = (dx < 0) ? -longint'(magy) : longint'(magy);
		if (dy == 0)
			nx = 0;
		if (dx == 0)
			ny = 0;
		push_vertex(0, x0 + nx, y0 + ny, c);
		push_vertex(1, sx + nx, sy + ny, c);
		push_vertex(2, sx - nx, sy - ny, c);
		push_vertex(3, x0 + nx, y0 + ny, c);
		push_vertex(4, sx - nx, sy - ny, c);
		push_vertex(5, x0 - nx, y0 - ny, c);
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return 24'($signed($urandom_range(0, 8191)) - 4096);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c = cmd_t'($bits(cmd_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
		c.operation = 1'($urandom_range(0, 1));
		c.start_x = rand_coord();
		c.start_y = rand_coord();
		if (c.operation == OP_RECT) begin
			// mostly drawable rectangles
			if ($urandom_range(0, 5) != 0) begin
				c.second_x = 24'($urandom_range(1, 4000));
				c.second_y = 24'($urandom_range(1, 4000));
			end else begin
				c.second_x = rand_coord();
				c.second_y = rand_coord();
			end
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					c.second_x = c.start_x;
					c.second_y = c.start_y;
				end
				1: begin
					c.second_x = c.start_x + 24'($signed($urandom_range(0, 2)) - 1);
					c.second_y = c.start_y;
				end
				2: begin
					c.second_x = c.start_x + 24'($signed($urandom_range(0, 20000)) - 10000);
					c.second_y = c.start_y + 24'($signed($urandom_range(0, 20000)) - 10000);
				end
				default: begin
					c.second_x = rand_coord();
					c.second_y = rand_coord();
				end
			endcase
		end
		return c;
	endfunction

	function automatic cmd_t make_cmd(input bit op, input int x0, input int y0,
			input int sx, input int sy, input int thick);
		cmd_t c;
		c.operation = op;
		c.start_x = 24'(x0);
		c.start_y = 24'(y0);
		c.second_x = 24'(sx);
		c.second_y = 24'(sy);
		c.thickness = 16'(thick);
		c.color_red = 8'($urandom);
		c.color_green = 8'($urandom);
		c.color_blue = 8'($urandom);
		c.color_alpha = 8'($urandom);
		return c;
	endfunction

	task automatic queue_cmd(input cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	initial begin
		cmd_t c;
		arst_n = 1'b0;
		stim_done = 1'b0;
		hold_off_req = 1'b0;
		pause_sender = 1'b0;
		errors = 0;
		// directed set
		queue_cmd(make_cmd(OP_RECT, 0, 0, 256, 512, 0));
		queue_cmd(make_cmd(OP_RECT, 100, 100, 0, 50, 7));
		queue_cmd(make_cmd(OP_RECT, 100, 100, 50, -1, 7));
		queue_cmd(make_cmd(OP_RECT, 8388607, 8388607, 8388607, 8388607, 65535));
		queue_cmd(make_cmd(OP_RECT, -8388608, -8388608, 1, 1, 0));
		queue_cmd(make_cmd(OP_RECT, 0, 0, -8388608, -8388608, 0));
		queue_cmd(make_cmd(OP_LINE, 0, 0, 2560, 0, 512));
		queue_cmd(make_cmd(OP_LINE, 0, 0, 0, 2560, 512));
		queue_cmd(make_cmd(OP_LINE, 0, 0, -2560, -2560, 768));
		queue_cmd(make_cmd(OP_LINE, 500, 500, 500, 500, 1024));
		queue_cmd(make_cmd(OP_LINE, 500, 500, 500, 500, 0));
		queue_cmd(make_cmd(OP_LINE, 500, 500, 501, 500, 256));
		queue_cmd(make_cmd(OP_LINE, -8388608, -8388608, 8388607, 8388607, 65535));
		queue_cmd(make_cmd(OP_LINE, 8388607, -8388608, -8388608, 8388607, 65535));
		queue_cmd(make_cmd(OP_LINE, 8388607, 0, 8388607, 100, 65535));
		queue_cmd(make_cmd(OP_LINE, 10, 20, 3000, -4000, 1));
		queue_cmd(make_cmd(OP_LINE, 10, 20, 3000, -4000, 0));
		c = make_cmd(OP_RECT, 3, 3, 9, 9, 0);
		c.color_red = 8'hFF;
		c.color_green = 8'hFF;
		c.color_blue = 8'hFF;
		c.color_alpha = 8'hFF;
		queue_cmd(c);
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < 410; i++) begin
			// long receiver hold-off while commands keep coming
			if (i == 150)
				hold_off_req = 1'b1;
			while (pending_cmds.size() > 20)
				@(negedge clk);
			queue_cmd(random_cmd());
			if (i == 300 || (pending_cmds.size() == 20 && ($urandom_range(0, 10) == 0))) begin
				// drain everything before going on
				wait (pending_cmds.size() == 0);
				pause_sender = 1'b1;
				wait (expected_vtx.size() == 0);
				repeat (60) @(negedge clk);
				pause_sender = 1'b0;
			end
		end
		wait (pending_cmds.size() == 0 && !cmd_valid);
		wait (expected_vtx.size() == 0);
		repeat (100) @(negedge clk);
		stim_done = 1'b1;
	end

	// command acceptance as seen at the rising edge
	always @(posedge clk) begin
		cmd_acc <= arst_n && cmd_valid && !cmd_stall;
	end

	// command driver
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			gap_left <= 0;
		end else if (cmd_valid && !cmd_acc) begin
			// hold word
		end else begin
			if (cmd_valid)
				pending_cmds.pop_front();
			if (gap_left > 0 || pause_sender) begin
				cmd_valid <= 1'b0;
				gap_left <= gap_left > 0 ? gap_left - 1 : 0;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds[0];
				cmd_valid <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 3);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver stall generator
	int stall_left;
	bit long_done;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_stall <= 1'b0;
			stall_left <= 0;
			long_done <= 1'b0;
		end else if (hold_off_req && !long_done) begin
			vtx_stall <= 1'b1;
			stall_left <= 400;
			long_done <= 1'b1;
		end else if (stall_left > 0) begin
			vtx_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			vtx_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 20) == 0) ? $urandom_range(10, 50)
				: $urandom_range(0, 3);
		end else begin
			vtx_stall <= 1'b0;
		end
	end

	// predict on command acceptance, check on vertex acceptance
	always @(posedge clk) begin
		vtx_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				expand_command(cmd);
			if (vtx_valid && !vtx_stall) begin
				if (expected_vtx.size() == 0) begin
					$display("%0t: unexpected vertex %p", $time, vtx);
					errors++;
				end else begin
					want = expected_vtx.pop_front();
					if (vtx !== want) begin
						$display("%0t: vertex mismatch expected %p actual %p",
							$time, want, vtx);
						errors++;
					end
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (vtx_valid && !vtx_stall)
				|| (!cmd_valid && expected_vtx.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else if (stim_done) begin
			if (errors == 0 && expected_vtx.size() == 0)
				$display("Verification passed");
			else
				$display("Verification failed");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
rtl/tlrts_pkg.sv
rtl/tlrts_sqrt.sv
rtl/tlrts_div.sv
rtl/thick_line_and_rect_triangle_setup_core.sv
rtl/tlrts_checker.sv
test/testbench.sv
